[hw/rtl/seg_isect_pkg.sv]
package seg_isect_pkg;

    localparam int COORD_WIDTH_DEF = 24;
    localparam int FRAC_BITS_DEF   = 8;

    localparam int TOL_W       = 16;
    localparam int CFG_INDEX_W = 1;
    localparam int OUT_DATA_W  = 8;

    // Five stages inside each point classifier, one output stage after them.
    localparam int CLASS_STAGES = 5;
    localparam int NUM_STAGES   = CLASS_STAGES + 1;

    localparam logic [TOL_W-1:0] TOL_RESET = 16'd655;

    localparam logic [CFG_INDEX_W-1:0] CFG_CROSS_TOL = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PROJ_TOL  = 1'b1;

    typedef enum logic [1:0] {
        PT_ON,
        PT_LEFT,
        PT_RIGHT
    } pt_class_t;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } pipe_ctrl_t;

endpackage

[hw/rtl/seg_isect_pipe_ctrl.sv]
module seg_isect_pipe_ctrl (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output seg_isect_pkg::pipe_ctrl_t ctrl
);

    localparam int NS = seg_isect_pkg::NUM_STAGES;

    logic [NS-1:0] valid_reg;
    logic [NS-1:0] valid_next;
    logic [NS-1:0] valid_in;
    logic [NS:0]   ready;

    assign valid_in = {valid_reg[NS-2:0], s_tvalid};

    always_comb begin
        ready[NS] = m_tready;
        for (int k = NS - 1; k >= 0; k--) begin
            ready[k] = !valid_reg[k] || ready[k+1];
        end
        for (int k = 0; k < NS; k++) begin
            valid_next[k] = ready[k] ? valid_in[k] : valid_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign ctrl.load = ready[NS-1:0];
    assign s_tready  = ready[0];
    assign m_tvalid  = valid_reg[NS-1];

endmodule

[hw/rtl/seg_isect_classify.sv]
module seg_isect_classify #(
    parameter int COORD_WIDTH = seg_isect_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = seg_isect_pkg::FRAC_BITS_DEF
) (
    input  logic                                         aclk,
    input  logic [seg_isect_pkg::CLASS_STAGES-1:0]       load,
    input  logic signed [COORD_WIDTH-1:0]                seg_sx,
    input  logic signed [COORD_WIDTH-1:0]                seg_sy,
    input  logic signed [COORD_WIDTH-1:0]                seg_ex,
    input  logic signed [COORD_WIDTH-1:0]                seg_ey,
    input  logic signed [COORD_WIDTH-1:0]                pt_x,
    input  logic signed [COORD_WIDTH-1:0]                pt_y,
    input  logic [seg_isect_pkg::TOL_W-1:0]              cross_tol,
    input  logic [seg_isect_pkg::TOL_W-1:0]              proj_tol,
    output seg_isect_pkg::pt_class_t                     pt_class
);

    localparam int TW  = seg_isect_pkg::TOL_W;
    localparam int DW  = COORD_WIDTH + 1;
    localparam int PW  = 2 * DW;
    localparam int SW  = PW + 1;
    localparam int LPW = PW + TW;
    localparam int CW  = (SW + 16 > 17 + 2 * FRAC_BITS) ? SW + 16 : 17 + 2 * FRAC_BITS;
    localparam int QW  = SW + 18;

    // Stage 0: differences.
    logic signed [DW-1:0] dx_reg, dy_reg, rx_reg, ry_reg;

    always_ff @(posedge aclk) begin
        if (load[0]) begin
            dx_reg <= DW'(seg_ex) - DW'(seg_sx);
            dy_reg <= DW'(seg_ey) - DW'(seg_sy);
            rx_reg <= DW'(pt_x) - DW'(seg_sx);
            ry_reg <= DW'(pt_y) - DW'(seg_sy);
        end
    end

    // Stage 1: products.
    logic signed [PW-1:0] p_dxry_reg, p_rxdy_reg, p_rxdx_reg, p_rydy_reg;
    logic signed [PW-1:0] sq_dx_reg, sq_dy_reg;
    logic                 seg_zero1_reg, pt_zero1_reg;

    always_ff @(posedge aclk) begin
        if (load[1]) begin
            p_dxry_reg    <= PW'(dx_reg) * PW'(ry_reg);
            p_rxdy_reg    <= PW'(rx_reg) * PW'(dy_reg);
            p_rxdx_reg    <= PW'(rx_reg) * PW'(dx_reg);
            p_rydy_reg    <= PW'(ry_reg) * PW'(dy_reg);
            sq_dx_reg     <= PW'(dx_reg) * PW'(dx_reg);
            sq_dy_reg     <= PW'(dy_reg) * PW'(dy_reg);
            seg_zero1_reg <= (dx_reg == '0) && (dy_reg == '0);
            pt_zero1_reg  <= (rx_reg == '0) && (ry_reg == '0);
        end
    end

    // Stage 2: cross product, dot product and squared length.
    logic signed [SW-1:0] cross_reg, dot2_reg;
    logic        [PW-1:0] len2_2_reg;
    logic                 seg_zero2_reg, pt_zero2_reg;

    always_ff @(posedge aclk) begin
        if (load[2]) begin
            cross_reg     <= SW'(p_dxry_reg) - SW'(p_rxdy_reg);
            dot2_reg      <= SW'(p_rxdx_reg) + SW'(p_rydy_reg);
            len2_2_reg    <= $unsigned(sq_dx_reg) + $unsigned(sq_dy_reg);
            seg_zero2_reg <= seg_zero1_reg;
            pt_zero2_reg  <= pt_zero1_reg;
        end
    end

    // Stage 3: tolerance compares on the cross product, scaled projection slack.
    logic signed [CW-1:0] c_w, t_w;
    logic                 near_w, left_w;

    assign c_w    = CW'(cross_reg) <<< 16;
    assign t_w    = $signed(CW'(cross_tol) << (2 * FRAC_BITS));
    assign near_w = (c_w < t_w) && (c_w > -t_w);
    assign left_w = c_w > t_w;

    logic signed [SW-1:0]  dot3_reg;
    logic        [PW-1:0]  len2_3_reg;
    logic        [LPW-1:0] lp_reg;
    logic                  near_reg, left_reg, seg_zero3_reg, pt_zero3_reg;

    always_ff @(posedge aclk) begin
        if (load[3]) begin
            dot3_reg      <= dot2_reg;
            len2_3_reg    <= len2_2_reg;
            lp_reg        <= LPW'(len2_2_reg) * LPW'(proj_tol);
            near_reg      <= near_w;
            left_reg      <= left_w;
            seg_zero3_reg <= seg_zero2_reg;
            pt_zero3_reg  <= pt_zero2_reg;
        end
    end

    // Stage 4: projection range check and final class.
    logic signed [QW-1:0] d16_w, lp_w, len16_w, lo_sum_w, hi_sum_w;
    logic                 on_w;
    seg_isect_pkg::pt_class_t class_next;
    seg_isect_pkg::pt_class_t class_reg;

    assign d16_w    = QW'(dot3_reg) <<< 16;
    assign lp_w     = $signed(QW'(lp_reg));
    assign len16_w  = $signed(QW'(len2_3_reg)) <<< 16;
    assign lo_sum_w = d16_w + lp_w;
    assign hi_sum_w = len16_w + lp_w - d16_w;
    assign on_w     = seg_zero3_reg ? pt_zero3_reg
                                    : (!lo_sum_w[QW-1] && !hi_sum_w[QW-1]);

    always_comb begin
        if (near_reg && on_w) begin
            class_next = seg_isect_pkg::PT_ON;
        end else if (left_reg) begin
            class_next = seg_isect_pkg::PT_LEFT;
        end else begin
            class_next = seg_isect_pkg::PT_RIGHT;
        end
    end

    always_ff @(posedge aclk) begin
        if (load[4]) begin
            class_reg <= class_next;
        end
    end

    assign pt_class = class_reg;

endmodule

[hw/rtl/segment_intersection_test.sv]
// Channel  Ports                        Content
// s_       s_tvalid s_tready s_tdata    a_start_x a_start_y a_end_x a_end_y
//                                       b_start_x b_start_y b_end_x b_end_y
// m_       m_tvalid m_tready m_tdata    intersects touching
// cfg_     cfg_wr_en cfg_index cfg_data 0: cross_tolerance, 1: projection_tolerance
//
// One item is accepted per cycle unless a stalled output backs up to s_tready. The six
// register stages are differences, products, sums, the tolerance compares with the slack
// multiplier, the projection check, and the output.
// Reset clears all valid bits and sets both tolerances to 655.
// A stalled result holds its stage; empty stages ahead of it still fill.
module segment_intersection_test #(
    parameter int COORD_WIDTH = seg_isect_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = seg_isect_pkg::FRAC_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
    input  logic [((8*COORD_WIDTH+7)/8)*8-1:0]     s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // intersects, touching, zero fill
    output logic [seg_isect_pkg::OUT_DATA_W-1:0]   m_tdata,
    input  logic                                   cfg_wr_en,
    input  logic [seg_isect_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [seg_isect_pkg::TOL_W-1:0]        cfg_data
);

    localparam int W  = COORD_WIDTH;
    localparam int TW = seg_isect_pkg::TOL_W;
    localparam int CS = seg_isect_pkg::CLASS_STAGES;

    logic [TW-1:0] cross_tol_reg, proj_tol_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cross_tol_reg <= seg_isect_pkg::TOL_RESET;
            proj_tol_reg  <= seg_isect_pkg::TOL_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                seg_isect_pkg::CFG_CROSS_TOL: begin
                    cross_tol_reg <= cfg_data;
                end
                seg_isect_pkg::CFG_PROJ_TOL: begin
                    proj_tol_reg <= cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    seg_isect_pkg::pipe_ctrl_t ctrl;

    seg_isect_pipe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .ctrl     (ctrl)
    );

    logic signed [W-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;

    assign ax0 = $signed(s_tdata[0*W +: W]);
    assign ay0 = $signed(s_tdata[1*W +: W]);
    assign ax1 = $signed(s_tdata[2*W +: W]);
    assign ay1 = $signed(s_tdata[3*W +: W]);
    assign bx0 = $signed(s_tdata[4*W +: W]);
    assign by0 = $signed(s_tdata[5*W +: W]);
    assign bx1 = $signed(s_tdata[6*W +: W]);
    assign by1 = $signed(s_tdata[7*W +: W]);

    seg_isect_pkg::pt_class_t r1, r2, r3, r4;

    seg_isect_classify #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_cls_a_bs (
        .aclk (aclk), .load (ctrl.load[CS-1:0]),
        .seg_sx (ax0), .seg_sy (ay0), .seg_ex (ax1), .seg_ey (ay1),
        .pt_x (bx0), .pt_y (by0),
        .cross_tol (cross_tol_reg), .proj_tol (proj_tol_reg), .pt_class (r1)
    );

    seg_isect_classify #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_cls_a_be (
        .aclk (aclk), .load (ctrl.load[CS-1:0]),
        .seg_sx (ax0), .seg_sy (ay0), .seg_ex (ax1), .seg_ey (ay1),
        .pt_x (bx1), .pt_y (by1),
        .cross_tol (cross_tol_reg), .proj_tol (proj_tol_reg), .pt_class (r2)
    );

    seg_isect_classify #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_cls_b_as (
        .aclk (aclk), .load (ctrl.load[CS-1:0]),
        .seg_sx (bx0), .seg_sy (by0), .seg_ex (bx1), .seg_ey (by1),
        .pt_x (ax0), .pt_y (ay0),
        .cross_tol (cross_tol_reg), .proj_tol (proj_tol_reg), .pt_class (r3)
    );

    seg_isect_classify #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_cls_b_ae (
        .aclk (aclk), .load (ctrl.load[CS-1:0]),
        .seg_sx (bx0), .seg_sy (by0), .seg_ex (bx1), .seg_ey (by1),
        .pt_x (ax1), .pt_y (ay1),
        .cross_tol (cross_tol_reg), .proj_tol (proj_tol_reg), .pt_class (r4)
    );

    logic touch_next, cross_next;
    logic intersects_reg, touching_reg;

    assign touch_next = (r1 == seg_isect_pkg::PT_ON) || (r2 == seg_isect_pkg::PT_ON) ||
                        (r3 == seg_isect_pkg::PT_ON) || (r4 == seg_isect_pkg::PT_ON);
    assign cross_next = (r1 != r2) && (r3 != r4);

    always_ff @(posedge aclk) begin
        if (ctrl.load[CS]) begin
            intersects_reg <= cross_next || touch_next;
            touching_reg   <= touch_next;
        end
    end

    assign m_tdata = {{(seg_isect_pkg::OUT_DATA_W-2){1'b0}}, touching_reg, intersects_reg};

endmodule

[hw/rtl/seg_isect_checker.sv]
module seg_isect_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 m_tvalid,
    input logic                                 m_tready,
    input logic [seg_isect_pkg::OUT_DATA_W-1:0] m_tdata
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or dropped while stalled");

    a_touch_implies_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[1] && !m_tdata[0]))
        else $error("touching reported without intersection");

    a_fill_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[seg_isect_pkg::OUT_DATA_W-1:2] == '0)
        else $error("fill bits of result not zero");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind segment_intersection_test seg_isect_checker u_seg_isect_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[tb/sv/tb.sv]
module tb;

    localparam int CW             = seg_isect_pkg::COORD_WIDTH_DEF;
    localparam int FB             = seg_isect_pkg::FRAC_BITS_DEF;
    localparam int TW             = seg_isect_pkg::TOL_W;
    localparam int DATA_W         = ((8 * CW + 7) / 8) * 8;
    localparam int CMAX           = 2 ** (CW - 1) - 1;
    localparam int CMIN           = -(2 ** (CW - 1));
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int REPORT_CAP     = 100;

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [127:0]  wide_t;

    // The first field sits in the lowest bits, so the fields are listed from the top down.
    typedef struct packed {
        coord_t b_end_y;
        coord_t b_end_x;
        coord_t b_start_y;
        coord_t b_start_x;
        coord_t a_end_y;
        coord_t a_end_x;
        coord_t a_start_y;
        coord_t a_start_x;
    } seg_pair_t;

    typedef struct {
        logic intersects;
        logic touching;
    } contact_t;

    logic                                  aclk = 1'b0;
    logic                                  aresetn = 1'b0;
    logic                                  s_tvalid = 1'b0;
    logic                                  s_tready;
    logic [DATA_W-1:0]                     s_tdata = '0;
    logic                                  m_tvalid;
    logic                                  m_tready = 1'b0;
    logic [seg_isect_pkg::OUT_DATA_W-1:0]  m_tdata;
    logic                                  cfg_wr_en = 1'b0;
    logic [seg_isect_pkg::CFG_INDEX_W-1:0] cfg_index = seg_isect_pkg::CFG_CROSS_TOL;
    logic [TW-1:0]                         cfg_data = '0;

    logic [TW-1:0] cross_tol_now = seg_isect_pkg::TOL_RESET;
    logic [TW-1:0] proj_tol_now = seg_isect_pkg::TOL_RESET;
    contact_t      pending_contacts[$];
    int            mismatch_count = 0;
    int            quiet_cycles = 0;
    int            burst_left = 0;
    bit            sender_steady = 1'b0;
    bit            hold_request = 1'b0;
    int            hold_left = 0;
    int            ready_run = 0;
    int            stall_run = 0;

    segment_intersection_test dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    function automatic seg_isect_pkg::pt_class_t classify_point(
        input coord_t sx, input coord_t sy,
        input coord_t ex, input coord_t ey,
        input coord_t px, input coord_t py);
        wide_t dx, dy, rx, ry, cross_p, lim, dot_p, len2, d16, slack;
        logic  on_seg;
        dx = wide_t'(ex) - wide_t'(sx);
        dy = wide_t'(ey) - wide_t'(sy);
        rx = wide_t'(px) - wide_t'(sx);
        ry = wide_t'(py) - wide_t'(sy);
        cross_p = (dx * ry - rx * dy) <<< 16;
        lim = wide_t'(cross_tol_now);
        lim = lim <<< (2 * FB);
        slack = wide_t'(proj_tol_now);
        on_seg = 1'b0;
        if ((-lim < cross_p) && (cross_p < lim)) begin
            if (dx == 0 && dy == 0) begin
                on_seg = (rx == 0) && (ry == 0);
            end else begin
                dot_p = rx * dx + ry * dy;
                len2 = dx * dx + dy * dy;
                d16 = dot_p <<< 16;
                on_seg = ((d16 + len2 * slack) >= 0) && !(len2 * (slack + 65536) < d16);
            end
        end
        if (on_seg)
            return seg_isect_pkg::PT_ON;
        if (lim < cross_p)
            return seg_isect_pkg::PT_LEFT;
        return seg_isect_pkg::PT_RIGHT;
    endfunction

    function automatic contact_t predict_contact(input seg_pair_t p);
        seg_isect_pkg::pt_class_t b0_vs_a, b1_vs_a, a0_vs_b, a1_vs_b;
        contact_t  r;
        b0_vs_a = classify_point(p.a_start_x, p.a_start_y, p.a_end_x, p.a_end_y,
                                 p.b_start_x, p.b_start_y);
        b1_vs_a = classify_point(p.a_start_x, p.a_start_y, p.a_end_x, p.a_end_y,
                                 p.b_end_x, p.b_end_y);
        a0_vs_b = classify_point(p.b_start_x, p.b_start_y, p.b_end_x, p.b_end_y,
                                 p.a_start_x, p.a_start_y);
        a1_vs_b = classify_point(p.b_start_x, p.b_start_y, p.b_end_x, p.b_end_y,
                                 p.a_end_x, p.a_end_y);
        r.touching = (b0_vs_a == seg_isect_pkg::PT_ON) || (b1_vs_a == seg_isect_pkg::PT_ON) ||
                     (a0_vs_b == seg_isect_pkg::PT_ON) || (a1_vs_b == seg_isect_pkg::PT_ON);
        r.intersects = ((b0_vs_a != b1_vs_a) && (a0_vs_b != a1_vs_b)) || r.touching;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_count < REPORT_CAP)
            $display("mismatch at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin
        contact_t want;
        if (!aresetn) begin
            cross_tol_now = seg_isect_pkg::TOL_RESET;
            proj_tol_now = seg_isect_pkg::TOL_RESET;
            pending_contacts.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_contacts.size() == 0) begin
                    report_mismatch("result arrived with no item pending");
                end else begin
                    want = pending_contacts.pop_front();
                    if (m_tdata[0] !== want.intersects)
                        report_mismatch($sformatf("intersects %b, predicted %b",
                                                  m_tdata[0], want.intersects));
                    if (m_tdata[1] !== want.touching)
                        report_mismatch($sformatf("touching %b, predicted %b",
                                                  m_tdata[1], want.touching));
                end
            end
            if (s_tvalid && s_tready)
                pending_contacts.push_back(predict_contact(seg_pair_t'(s_tdata)));
            if (cfg_wr_en) begin
                if (cfg_index == seg_isect_pkg::CFG_CROSS_TOL)
                    cross_tol_now = cfg_data;
                else if (cfg_index == seg_isect_pkg::CFG_PROJ_TOL)
                    proj_tol_now = cfg_data;
            end
        end
    end

    always @(posedge aclk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (ready_run > 0) begin
            ready_run--;
            m_tready <= 1'b1;
        end else if (stall_run > 0) begin
            stall_run--;
            m_tready <= 1'b0;
        end else begin
            ready_run = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 160)
                                                    : $urandom_range(0, 8);
            stall_run = $urandom_range(1, 5);
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || cfg_wr_en || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic send_pair(input seg_pair_t p);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 12);
            gap = sender_steady ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= p;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_contacts.size() != 0) @(posedge aclk);
        repeat (seg_isect_pkg::NUM_STAGES + 2) @(posedge aclk);
    endtask

    task automatic set_tolerances(input logic [TW-1:0] cross_tol,
                                  input logic [TW-1:0] proj_tol);
        cfg_wr_en <= 1'b1;
        cfg_index <= seg_isect_pkg::CFG_CROSS_TOL;
        cfg_data <= cross_tol;
        @(posedge aclk);
        cfg_index <= seg_isect_pkg::CFG_PROJ_TOL;
        cfg_data <= proj_tol;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic seg_pair_t pair_of(input int ax0, input int ay0, input int ax1,
                                          input int ay1, input int bx0, input int by0,
                                          input int bx1, input int by1);
        seg_pair_t p;
        p.a_start_x = coord_t'(ax0);
        p.a_start_y = coord_t'(ay0);
        p.a_end_x = coord_t'(ax1);
        p.a_end_y = coord_t'(ay1);
        p.b_start_x = coord_t'(bx0);
        p.b_start_y = coord_t'(by0);
        p.b_end_x = coord_t'(bx1);
        p.b_end_y = coord_t'(by1);
        return p;
    endfunction

    function automatic int near_coord(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic int extreme_coord();
        case ($urandom_range(0, 4))
            0: return CMIN;
            1: return CMAX;
            2: return 0;
            3: return -1;
            default: return 1;
        endcase
    endfunction

    function automatic seg_pair_t random_pair();
        seg_pair_t p;
        int        pick, dx, dy, k0, k1;
        pick = $urandom_range(0, 99);
        p = pair_of(near_coord(512), near_coord(512), near_coord(512), near_coord(512),
                    near_coord(512), near_coord(512), near_coord(512), near_coord(512));
        if (pick < 15) begin
            p = seg_pair_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        end else if (pick < 40) begin
            // plain short segments around the origin
        end else if (pick < 60) begin
            case ($urandom_range(0, 3))
                0: {p.b_start_x, p.b_start_y} = {p.a_start_x, p.a_start_y};
                1: {p.b_start_x, p.b_start_y} = {p.a_end_x, p.a_end_y};
                2: {p.b_end_x, p.b_end_y} = {p.a_start_x, p.a_start_y};
                default: {p.b_end_x, p.b_end_y} = {p.a_end_x, p.a_end_y};
            endcase
        end else if (pick < 85) begin
            p.a_start_x = coord_t'(near_coord(4096));
            p.a_start_y = coord_t'(near_coord(4096));
            dx = near_coord(48);
            dy = near_coord(48);
            k0 = int'($urandom_range(0, 6)) - 2;
            k1 = int'($urandom_range(0, 6)) - 2;
            p.a_end_x = p.a_start_x + coord_t'(2 * dx);
            p.a_end_y = p.a_start_y + coord_t'(2 * dy);
            p.b_start_x = p.a_start_x + coord_t'(k0 * dx + int'($urandom_range(0, 2)) - 1);
            p.b_start_y = p.a_start_y + coord_t'(k0 * dy + int'($urandom_range(0, 2)) - 1);
            p.b_end_x = p.a_start_x + coord_t'(k1 * dx + int'($urandom_range(0, 2)) - 1);
            p.b_end_y = p.a_start_y + coord_t'(k1 * dy + int'($urandom_range(0, 2)) - 1);
        end else if (pick < 95) begin
            {p.a_end_x, p.a_end_y} = {p.a_start_x, p.a_start_y};
            if ($urandom_range(0, 1) == 0)
                {p.b_start_x, p.b_start_y} = {p.a_start_x, p.a_start_y};
            if ($urandom_range(0, 2) == 0)
                {p.b_end_x, p.b_end_y} = {p.b_start_x, p.b_start_y};
        end else begin
            p = pair_of(extreme_coord(), extreme_coord(), extreme_coord(), extreme_coord(),
                        extreme_coord(), extreme_coord(), extreme_coord(), extreme_coord());
        end
        return p;
    endfunction

    task automatic send_random_pairs(input int count);
        repeat (count) send_pair(random_pair());
    endtask

    task automatic test_directed();
        send_pair(pair_of(-256, 0, 256, 0, 0, -256, 0, 256));
        send_pair(pair_of(0, 0, 256, 0, 0, 256, 256, 256));
        send_pair(pair_of(0, 0, 512, 0, 256, 0, 768, 0));
        send_pair(pair_of(0, 0, 256, 0, 512, 0, 768, 0));
        send_pair(pair_of(0, 0, 512, 0, 256, 0, 256, 256));
        send_pair(pair_of(0, 0, 256, 0, 256, 0, 512, 256));
        send_pair(pair_of(0, 0, 1, 0, 0, 655, 0, 2000));
        send_pair(pair_of(0, 0, 1, 0, 0, 654, 0, 2000));
        send_pair(pair_of(0, 0, 1, 0, 0, -655, 0, -2000));
        send_pair(pair_of(0, 0, 1, 0, 0, -654, 0, -2000));
        send_pair(pair_of(0, 0, 256, 0, -2, 0, -2, -5000));
        send_pair(pair_of(0, 0, 256, 0, -3, 0, -3, -5000));
        send_pair(pair_of(0, 0, 256, 0, 258, 0, 258, -5000));
        send_pair(pair_of(0, 0, 256, 0, 259, 0, 259, -5000));
        send_pair(pair_of(100, 100, 100, 100, 100, 100, 500, 500));
        send_pair(pair_of(100, 100, 100, 100, -100, -100, 300, 300));
        send_pair(pair_of(100, 100, 100, 100, 0, 0, 0, 500));
        send_pair(pair_of(7, -7, 7, -7, 7, -7, 7, -7));
        send_pair(pair_of(7, -7, 7, -7, 8, -7, 8, -7));
        send_pair(pair_of(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
        send_pair(pair_of(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN));
        send_pair(pair_of(CMAX, CMIN, CMIN, CMAX, -1, -1, 1, 1));
        send_pair(pair_of(CMIN, 0, CMAX, 0, CMAX, 0, CMAX, CMAX));
        send_pair(pair_of(CMIN, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX));
        wait_drained();
    endtask

    task automatic test_random_default();
        send_random_pairs(300);
        wait_drained();
    endtask

    task automatic test_backpressure();
        sender_steady = 1'b1;
        burst_left = 0;
        hold_request = 1'b1;
        send_random_pairs(150);
        sender_steady = 1'b0;
        wait_drained();
    endtask

    task automatic test_tolerance_sweep();
        logic [TW-1:0] cross_set[7];
        logic [TW-1:0] proj_set[7];
        cross_set = '{16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd1, 16'd0,
                      seg_isect_pkg::TOL_RESET};
        proj_set = '{16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFE, 16'd0,
                     seg_isect_pkg::TOL_RESET};
        cross_set[5] = TW'($urandom_range(0, 65535));
        proj_set[5] = TW'($urandom_range(0, 65535));
        for (int i = 0; i < 7; i++) begin
            set_tolerances(cross_set[i], proj_set[i]);
            send_random_pairs(80);
            wait_drained();
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random_default();
        test_backpressure();
        test_tolerance_sweep();
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/seg_isect_pkg.sv
hw/rtl/seg_isect_pipe_ctrl.sv
hw/rtl/seg_isect_classify.sv
hw/rtl/segment_intersection_test.sv
hw/rtl/seg_isect_checker.sv
tb/sv/tb.sv
